// File: rtl/core/cmsy_pkg.sv
package cmsy_pkg;

  // Register map: index = paddr[4:2]
  localparam int unsigned CFG_AW = 5;
  localparam logic [2:0] REG_FORWARD_TIME = 3'd0;
  localparam logic [2:0] REG_TURN_TIME    = 3'd1;
  localparam logic [2:0] REG_BACK_TIME    = 3'd2;
  localparam logic [2:0] REG_WHEEL_RPM    = 3'd3;
  localparam logic [2:0] REG_SPIN_CODE    = 3'd4;
  localparam logic [2:0] REG_OMEGA_LIMIT  = 3'd5;
  localparam logic [2:0] REG_FOLLOW_GAIN  = 3'd6;
  localparam logic [2:0] REG_DEADBAND     = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_FORWARD_TIME = 16'd6000;
  localparam logic [15:0] RST_TURN_TIME    = 16'd5000;
  localparam logic [15:0] RST_BACK_TIME    = 16'd3000;
  localparam logic [10:0] RST_WHEEL_RPM    = 11'd800;
  localparam logic [10:0] RST_SPIN_CODE    = 11'd770;
  localparam logic [9:0]  RST_OMEGA_LIMIT  = 10'd520;
  localparam logic [5:0]  RST_FOLLOW_GAIN  = 6'd10;
  localparam logic [7:0]  RST_DEADBAND     = 8'd8;

  // Body yaw (radians / 100 as signed Q1.14) to degrees: (|b| * 5867088) >> 24
  localparam logic [22:0] YAW_DEG_MUL = 23'd5867088;

  // Angle wrap: v / 360 as (v * 46604) >> 24, exact for v < 2^16
  localparam logic [15:0] WRAP_RECIP = 16'd46604;
  localparam logic signed [17:0] WRAP_HI  = 18'sd180;
  localparam logic signed [17:0] WRAP_LO  = -18'sd180;
  localparam logic signed [17:0] WRAP_BIAS = 18'sd181;
  localparam logic signed [9:0]  WRAP_BASE = 10'sd179;

  localparam logic signed [17:0] FOLLOW_OFFSET = 18'sd4;
  localparam logic [10:0] MAX_WHEEL = 11'd2000;

  localparam logic [1:0] PHASE_FORWARD = 2'd0;
  localparam logic [1:0] PHASE_TURN    = 2'd1;
  localparam logic [1:0] PHASE_BACK    = 2'd2;

  typedef struct packed {
    logic [15:0] forward_time_ms;
    logic [15:0] turn_time_ms;
    logic [15:0] back_time_ms;
    logic [10:0] routine_wheel_rpm;
    logic [10:0] spin_code;
    logic [9:0]  omega_limit;
    logic [5:0]  follow_gain;
    logic [7:0]  deadband_deg;
  } cfg_t;

  // Controller to datapath step commands
  typedef struct packed {
    logic load;
    logic mode_upd;
    logic wrap_mul;
    logic wrap_fin;
    logic wrap_err;
    logic err_calc;
    logic gain_mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/cmsy_ctrl.sv
module cmsy_ctrl import cmsy_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MODE   = 4'd1;
  localparam logic [3:0] ST_WMUL_D = 4'd2;
  localparam logic [3:0] ST_WFIN_D = 4'd3;
  localparam logic [3:0] ST_ERR    = 4'd4;
  localparam logic [3:0] ST_WMUL_E = 4'd5;
  localparam logic [3:0] ST_WFIN_E = 4'd6;
  localparam logic [3:0] ST_GAIN   = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // Step sequencing
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MODE;
        end
      end
      ST_MODE: begin
        cmd_o.mode_upd = 1'b1;
        state_d        = ST_WMUL_D;
      end
      ST_WMUL_D: begin
        cmd_o.wrap_mul = 1'b1;
        state_d        = ST_WFIN_D;
      end
      ST_WFIN_D: begin
        cmd_o.wrap_fin = 1'b1;
        state_d        = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.err_calc = 1'b1;
        state_d        = ST_WMUL_E;
      end
      ST_WMUL_E: begin
        cmd_o.wrap_mul = 1'b1;
        cmd_o.wrap_err = 1'b1;
        state_d        = ST_WFIN_E;
      end
      ST_WFIN_E: begin
        cmd_o.wrap_fin = 1'b1;
        cmd_o.wrap_err = 1'b1;
        state_d        = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.gain_mul = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/cmsy_dp.sv
module cmsy_dp import cmsy_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [31:0]        tick_ms_i,
  input  logic [10:0]        switch_channel_i,
  input  logic signed [15:0] gimbal_yaw_deg_i,
  input  logic signed [15:0] body_yaw_i,
  input  logic               follow_on_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               auto_mode_o,
  output logic [1:0]         routine_phase_o,
  output logic signed [10:0] rotation_rate_o,
  output logic signed [11:0] wheel_pair_a_rpm_o,
  output logic signed [11:0] wheel_pair_b_rpm_o
);

  // Latched request
  logic [31:0]        tick_q;
  logic [10:0]        sw_q;
  logic signed [15:0] gimbal_q;
  logic signed [15:0] body_q;
  logic               follow_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tick_q   <= tick_ms_i;
      sw_q     <= switch_channel_i;
      gimbal_q <= gimbal_yaw_deg_i;
      body_q   <= body_yaw_i;
      follow_q <= follow_on_i;
    end
  end

  // Mode / trigger / routine phase sequencing
  logic        mode_q, mode_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] start_q, start_d;
  logic        seen_off_q, seen_off_d;
  logic        seen_spin_q, seen_spin_d;
  logic [31:0] elapsed;
  logic        sw_is_spin;

  assign elapsed    = tick_q - start_q;
  assign sw_is_spin = (sw_q == cfg_i.spin_code);

  always_comb begin
    mode_d      = mode_q;
    phase_d     = phase_q;
    start_d     = start_q;
    seen_off_d  = seen_off_q;
    seen_spin_d = seen_spin_q;
    if (!mode_q) begin
      if (!sw_is_spin) begin
        if (seen_off_q && seen_spin_q) begin
          mode_d      = 1'b1;
          phase_d     = PHASE_FORWARD;
          start_d     = tick_q;
          seen_off_d  = 1'b0;
          seen_spin_d = 1'b0;
        end else begin
          seen_off_d = 1'b1;
        end
      end else if (seen_off_q) begin
        seen_spin_d = 1'b1;
      end
    end else begin
      priority if (phase_q == PHASE_FORWARD) begin
        if (elapsed >= 32'(cfg_i.forward_time_ms)) begin
          phase_d = PHASE_TURN;
          start_d = tick_q;
        end
      end else if (phase_q == PHASE_TURN) begin
        if (elapsed >= 32'(cfg_i.turn_time_ms)) begin
          phase_d = PHASE_BACK;
          start_d = tick_q;
        end
      end else begin
        if (elapsed >= 32'(cfg_i.back_time_ms)) begin
          mode_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      phase_q     <= PHASE_FORWARD;
      start_q     <= '0;
      seen_off_q  <= 1'b0;
      seen_spin_q <= 1'b0;
    end else if (cmd_i.mode_upd) begin
      mode_q      <= mode_d;
      phase_q     <= phase_d;
      start_q     <= start_d;
      seen_off_q  <= seen_off_d;
      seen_spin_q <= seen_spin_d;
    end
  end

  // Body yaw to degrees, magnitude multiply
  logic [15:0] body_mag;
  logic [38:0] yaw_prod_q;
  logic        yaw_neg_q;

  assign body_mag = body_q[15] ? (~body_q + 16'd1) : body_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mode_upd) begin
      yaw_prod_q <= 39'(body_mag) * 39'(YAW_DEG_MUL);
      yaw_neg_q  <= body_q[15];
    end
  end

  logic signed [17:0] deg_raw;
  logic signed [17:0] deg_mag;

  assign deg_mag = $signed({3'b000, yaw_prod_q[38:24]});
  assign deg_raw = yaw_neg_q ? -deg_mag : deg_mag;

  // Shared angle wrap unit: multiply step, then remainder step
  logic signed [17:0] err_q;
  logic signed [17:0] wrap_x;
  logic               wrap_pos, wrap_neg;
  logic signed [17:0] wrap_diff;
  logic [31:0]        wrap_prod;
  logic [7:0]         wrap_quo_q;
  logic [15:0]        wrap_v_q;
  logic signed [9:0]  wrap_x_q;
  logic               wrap_pos_q, wrap_neg_q;
  logic [15:0]        wrap_rem;
  logic signed [9:0]  wrap_r;
  logic signed [9:0]  wrap_res;
  logic signed [9:0]  deg_w_q;
  logic signed [9:0]  err_w_q;

  assign wrap_x    = cmd_i.wrap_err ? err_q : deg_raw;
  assign wrap_pos  = (wrap_x > WRAP_HI);
  assign wrap_neg  = (wrap_x < WRAP_LO);
  assign wrap_diff = wrap_pos ? (wrap_x - WRAP_BIAS) : (-WRAP_BIAS - wrap_x);
  assign wrap_prod = 32'(wrap_diff[15:0]) * 32'(WRAP_RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wrap_mul) begin
      wrap_quo_q <= wrap_prod[31:24];
      wrap_v_q   <= wrap_diff[15:0];
      wrap_x_q   <= wrap_x[9:0];
      wrap_pos_q <= wrap_pos;
      wrap_neg_q <= wrap_neg;
    end
  end

  assign wrap_rem = wrap_v_q - (16'(wrap_quo_q) * 16'd360);
  assign wrap_r   = $signed({1'b0, wrap_rem[8:0]});

  always_comb begin
    priority if (wrap_pos_q) begin
      wrap_res = wrap_r - WRAP_BASE;
    end else if (wrap_neg_q) begin
      wrap_res = WRAP_BASE - wrap_r;
    end else begin
      wrap_res = wrap_x_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wrap_fin) begin
      if (cmd_i.wrap_err) begin
        err_w_q <= wrap_res;
      end else begin
        deg_w_q <= wrap_res;
      end
    end
  end

  // Yaw error with offset and deadband
  logic signed [17:0] err_raw;
  logic signed [17:0] err_abs;
  logic               err_zero;

  assign err_raw  = 18'(deg_w_q) - 18'(gimbal_q) + FOLLOW_OFFSET;
  assign err_abs  = err_raw[17] ? -err_raw : err_raw;
  assign err_zero = (err_abs < $signed({10'd0, cfg_i.deadband_deg})) || !follow_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_calc) begin
      err_q <= err_zero ? '0 : err_raw;
    end
  end

  // Gain multiply and clamp
  logic signed [16:0] rate_prod_q;
  logic signed [16:0] lim;
  logic signed [16:0] rate_cl;

  always_ff @(posedge clk_i) begin
    if (cmd_i.gain_mul) begin
      rate_prod_q <= $signed({1'b0, cfg_i.follow_gain}) * err_w_q;
    end
  end

  assign lim = $signed({7'd0, cfg_i.omega_limit});

  always_comb begin
    priority if (rate_prod_q > lim) begin
      rate_cl = lim;
    end else if (rate_prod_q < -lim) begin
      rate_cl = -lim;
    end else begin
      rate_cl = rate_prod_q;
    end
  end

  // Result fields
  logic [10:0]        rpm_sat;
  logic signed [11:0] rpm12;
  logic signed [10:0] rate_sel;
  logic signed [11:0] wa_sel, wb_sel;
  logic [1:0]         phase_sel;

  assign rpm_sat = (cfg_i.routine_wheel_rpm > MAX_WHEEL) ? MAX_WHEEL : cfg_i.routine_wheel_rpm;
  assign rpm12   = $signed({1'b0, rpm_sat});

  always_comb begin
    rate_sel  = '0;
    wa_sel    = '0;
    wb_sel    = '0;
    phase_sel = PHASE_FORWARD;
    if (mode_q) begin
      phase_sel = phase_q;
      priority if (phase_q == PHASE_FORWARD) begin
        wa_sel = rpm12;
      end else if (phase_q == PHASE_TURN) begin
        wb_sel = rpm12;
      end else begin
        wa_sel = -rpm12;
      end
    end else if (sw_is_spin) begin
      rate_sel = $signed({1'b0, cfg_i.omega_limit});
    end else begin
      rate_sel = rate_cl[10:0];
    end
  end

  // Output register
  logic out_valid_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      auto_mode_o        <= mode_q;
      routine_phase_o    <= phase_sel;
      rotation_rate_o    <= rate_sel;
      wheel_pair_a_rpm_o <= wa_sel;
      wheel_pair_b_rpm_o <= wb_sel;
    end
  end

endmodule

// File: rtl/core/chassis_mode_sequencer_yaw_follow_unit.sv
// Per request the step sequencer runs the mode update and yaw multiply, a pass
// through the shared angle wrap unit for the degrees, the yaw error, a second pass
// for the error, gain multiply, output load; input stalls till the sequencer idles.
// A stalled result still lets one more request in; that one waits at the output step
// and the input stalls until the output register frees.
// Reset (rst_ni, async low): manual mode, forward phase, trigger flags clear,
// configuration registers at their default values.
module chassis_mode_sequencer_yaw_follow_unit import cmsy_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        tick_ms_i,
  input  logic [10:0]        switch_channel_i,
  input  logic signed [15:0] gimbal_yaw_deg_i,
  input  logic signed [15:0] body_yaw_i,
  input  logic               follow_on_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               auto_mode_o,
  output logic [1:0]         routine_phase_o,
  output logic signed [10:0] rotation_rate_o,
  output logic signed [11:0] wheel_pair_a_rpm_o,
  output logic signed [11:0] wheel_pair_b_rpm_o
);

  cfg_t       cfg_q;
  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.forward_time_ms   <= RST_FORWARD_TIME;
      cfg_q.turn_time_ms      <= RST_TURN_TIME;
      cfg_q.back_time_ms      <= RST_BACK_TIME;
      cfg_q.routine_wheel_rpm <= RST_WHEEL_RPM;
      cfg_q.spin_code         <= RST_SPIN_CODE;
      cfg_q.omega_limit       <= RST_OMEGA_LIMIT;
      cfg_q.follow_gain       <= RST_FOLLOW_GAIN;
      cfg_q.deadband_deg      <= RST_DEADBAND;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FORWARD_TIME: cfg_q.forward_time_ms   <= pwdata[15:0];
        REG_TURN_TIME:    cfg_q.turn_time_ms      <= pwdata[15:0];
        REG_BACK_TIME:    cfg_q.back_time_ms      <= pwdata[15:0];
        REG_WHEEL_RPM:    cfg_q.routine_wheel_rpm <= pwdata[10:0];
        REG_SPIN_CODE:    cfg_q.spin_code         <= pwdata[10:0];
        REG_OMEGA_LIMIT:  cfg_q.omega_limit       <= pwdata[9:0];
        REG_FOLLOW_GAIN:  cfg_q.follow_gain       <= pwdata[5:0];
        REG_DEADBAND:     cfg_q.deadband_deg      <= pwdata[7:0];
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_FORWARD_TIME: prdata = 32'(cfg_q.forward_time_ms);
      REG_TURN_TIME:    prdata = 32'(cfg_q.turn_time_ms);
      REG_BACK_TIME:    prdata = 32'(cfg_q.back_time_ms);
      REG_WHEEL_RPM:    prdata = 32'(cfg_q.routine_wheel_rpm);
      REG_SPIN_CODE:    prdata = 32'(cfg_q.spin_code);
      REG_OMEGA_LIMIT:  prdata = 32'(cfg_q.omega_limit);
      REG_FOLLOW_GAIN:  prdata = 32'(cfg_q.follow_gain);
      REG_DEADBAND:     prdata = 32'(cfg_q.deadband_deg);
    endcase
  end

  cmsy_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cmsy_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .tick_ms_i          (tick_ms_i),
    .switch_channel_i   (switch_channel_i),
    .gimbal_yaw_deg_i   (gimbal_yaw_deg_i),
    .body_yaw_i         (body_yaw_i),
    .follow_on_i        (follow_on_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .auto_mode_o        (auto_mode_o),
    .routine_phase_o    (routine_phase_o),
    .rotation_rate_o    (rotation_rate_o),
    .wheel_pair_a_rpm_o (wheel_pair_a_rpm_o),
    .wheel_pair_b_rpm_o (wheel_pair_b_rpm_o)
  );

`ifndef SYNTHESIS
  // Routine results carry no rotation command
  a_routine_no_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && auto_mode_o) |-> (rotation_rate_o == 11'sd0))
    else $error("rotation command during routine");

  // Manual results carry no wheel targets and phase zero
  a_manual_no_wheels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !auto_mode_o) |->
      (wheel_pair_a_rpm_o == 12'sd0 && wheel_pair_b_rpm_o == 12'sd0 &&
       routine_phase_o == PHASE_FORWARD))
    else $error("wheel targets in manual mode");

  // Rotation command stays within the clamp
  a_rate_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ($signed({1'b0, rotation_rate_o[10] ? -rotation_rate_o : rotation_rate_o})
       <= $signed({2'b00, cfg_q.omega_limit})))
    else $error("rotation command beyond limit");

  // A stalled result stays valid and unchanged
  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable({auto_mode_o, routine_phase_o, rotation_rate_o,
                               wheel_pair_a_rpm_o, wheel_pair_b_rpm_o})))
    else $error("stalled result changed");
`endif

endmodule

// File: bench/tb_chassis_mode_sequencer_yaw_follow_unit.sv
`timescale 1ns / 1ps

module tb_chassis_mode_sequencer_yaw_follow_unit import cmsy_pkg::*;;

  localparam longint YAW_SCALE  = 5867088;
  localparam int     ROUTE_MAX  = 2000;
  localparam int     YAW_OFFSET = 4;
  localparam int     HOLD_LEN   = 300;
  localparam int     SETTLE_CYC = 12;
  localparam int     MAX_PRINTS = 40;

  // one control tick as it enters the block
  typedef struct packed {
    logic [31:0]        tick;
    logic [10:0]        sw;
    logic signed [15:0] gimbal;
    logic signed [15:0] body;
    logic               follow;
  } tick_req_t;

  // chassis command produced for one tick
  typedef struct packed {
    logic               auto_mode;
    logic [1:0]         phase;
    logic signed [10:0] rate;
    logic signed [11:0] wheel_a;
    logic signed [11:0] wheel_b;
  } chassis_cmd_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [CFG_AW-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [31:0]        tick_ms_i;
  logic [10:0]        switch_channel_i;
  logic signed [15:0] gimbal_yaw_deg_i;
  logic signed [15:0] body_yaw_i;
  logic               follow_on_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               auto_mode_o;
  logic [1:0]         routine_phase_o;
  logic signed [10:0] rotation_rate_o;
  logic signed [11:0] wheel_pair_a_rpm_o;
  logic signed [11:0] wheel_pair_b_rpm_o;

  chassis_mode_sequencer_yaw_follow_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .tick_ms_i          (tick_ms_i),
    .switch_channel_i   (switch_channel_i),
    .gimbal_yaw_deg_i   (gimbal_yaw_deg_i),
    .body_yaw_i         (body_yaw_i),
    .follow_on_i        (follow_on_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .auto_mode_o        (auto_mode_o),
    .routine_phase_o    (routine_phase_o),
    .rotation_rate_o    (rotation_rate_o),
    .wheel_pair_a_rpm_o (wheel_pair_a_rpm_o),
    .wheel_pair_b_rpm_o (wheel_pair_b_rpm_o)
  );

  // shadow configuration and sequencer state
  cfg_t        cfg;
  logic        mode_auto   = 1'b0;
  logic [1:0]  phase_now   = PHASE_FORWARD;
  logic [31:0] phase_start = '0;
  logic        armed_off   = 1'b0;
  logic        armed_spin  = 1'b0;

  chassis_cmd_t chassis_cmd_q[$];
  int unsigned  err_count  = 0;
  logic [31:0]  tick_clock = '0;
  bit           hold_req   = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int wrap_angle(input int x);
    if (x > 180) return ((x - 181) % 360) - 179;
    if (x < -180) return 179 - ((-181 - x) % 360);
    return x;
  endfunction

  // body yaw (radians / 100 as signed Q1.14) to degrees, truncated toward zero
  function automatic int yaw_to_deg(input logic signed [15:0] b);
    longint mag;
    longint d;
    mag = (b < 0) ? -longint'(b) : longint'(b);
    d = (mag * YAW_SCALE) >>> 24;
    return (b < 0) ? -int'(d) : int'(d);
  endfunction

  function automatic chassis_cmd_t next_chassis_cmd(input tick_req_t r);
    chassis_cmd_t o;
    logic [31:0]  elapsed;
    int           rpm;
    int           deg;
    int           err;
    int           aerr;
    int           lim;
    int           rate;
    o = '0;
    // mode and phase update comes first
    if (!mode_auto) begin
      if (r.sw != cfg.spin_code) begin
        if (armed_off && armed_spin) begin
          mode_auto   = 1'b1;
          phase_now   = PHASE_FORWARD;
          phase_start = r.tick;
          armed_off   = 1'b0;
          armed_spin  = 1'b0;
        end else begin
          armed_off = 1'b1;
        end
      end else if (armed_off) begin
        armed_spin = 1'b1;
      end
    end else begin
      elapsed = r.tick - phase_start;
      case (phase_now)
        PHASE_FORWARD: begin
          if (elapsed >= 32'(cfg.forward_time_ms)) begin
            phase_now   = PHASE_TURN;
            phase_start = r.tick;
          end
        end
        PHASE_TURN: begin
          if (elapsed >= 32'(cfg.turn_time_ms)) begin
            phase_now   = PHASE_BACK;
            phase_start = r.tick;
          end
        end
        default: begin
          if (elapsed >= 32'(cfg.back_time_ms)) mode_auto = 1'b0;
        end
      endcase
    end

    // outputs reflect the updated state
    if (mode_auto) begin
      rpm = (int'(cfg.routine_wheel_rpm) > ROUTE_MAX) ? ROUTE_MAX : int'(cfg.routine_wheel_rpm);
      o.phase = phase_now;
      case (phase_now)
        PHASE_FORWARD: o.wheel_a = 12'(rpm);
        PHASE_TURN:    o.wheel_b = 12'(rpm);
        default:       o.wheel_a = 12'(-rpm);
      endcase
    end else if (r.sw == cfg.spin_code) begin
      o.rate = 11'(int'(cfg.omega_limit));
    end else begin
      deg  = wrap_angle(yaw_to_deg(r.body));
      err  = deg - int'($signed(r.gimbal)) + YAW_OFFSET;
      aerr = (err < 0) ? -err : err;
      lim  = int'(cfg.omega_limit);
      // deadband is tested before the wrap
      if (aerr < int'(cfg.deadband_deg) || !r.follow) err = 0;
      err  = wrap_angle(err);
      rate = int'(cfg.follow_gain) * err;
      if (rate > lim) rate = lim;
      if (rate < -lim) rate = -lim;
      o.rate = 11'(rate);
    end
    o.auto_mode = mode_auto;
    return o;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= MAX_PRINTS)
        $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
    end
  endtask

  // compare each accepted result with the oldest pending one
  always @(posedge clk_i) begin : result_check
    chassis_cmd_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (chassis_cmd_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_PRINTS)
          $display("%0t: result with no pending request, expected none actual %0h", $time,
                   {auto_mode_o, routine_phase_o, rotation_rate_o, wheel_pair_a_rpm_o,
                    wheel_pair_b_rpm_o});
      end else begin
        want = chassis_cmd_q.pop_front();
        check_field("auto_mode", 32'(want.auto_mode), 32'(auto_mode_o));
        check_field("routine_phase", 32'(want.phase), 32'(routine_phase_o));
        check_field("rotation_rate", 32'(unsigned'(want.rate)),
                    32'(unsigned'(rotation_rate_o)));
        check_field("wheel_pair_a_rpm", 32'(unsigned'(want.wheel_a)),
                    32'(unsigned'(wheel_pair_a_rpm_o)));
        check_field("wheel_pair_b_rpm", 32'(unsigned'(want.wheel_b)),
                    32'(unsigned'(wheel_pair_b_rpm_o)));
      end
    end
  end

  // ---------------------------------------------------------------- receiver stalls

  initial begin : rx_stall_gen
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned hold_left;
    int unsigned pick;
    bit          stall_next;
    stall_left = 0;
    free_left  = 0;
    hold_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        stall_next = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      free_left  = $urandom_range(0, 3);
        else if (pick < 65) free_left  = $urandom_range(20, 80);
        else if (pick < 93) stall_left = $urandom_range(0, 2);
        else                stall_left = $urandom_range(15, 50);
        stall_next = (pick >= 65);
      end
      out_stall_i <= stall_next;
    end
  end

  // ---------------------------------------------------------------- config port

  // write one register, then read it back
  task automatic cfg_write_verify(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] want;
    logic [31:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FORWARD_TIME: begin cfg.forward_time_ms   = val[15:0]; want = 32'(val[15:0]); end
      REG_TURN_TIME:    begin cfg.turn_time_ms      = val[15:0]; want = 32'(val[15:0]); end
      REG_BACK_TIME:    begin cfg.back_time_ms      = val[15:0]; want = 32'(val[15:0]); end
      REG_WHEEL_RPM:    begin cfg.routine_wheel_rpm = val[10:0]; want = 32'(val[10:0]); end
      REG_SPIN_CODE:    begin cfg.spin_code         = val[10:0]; want = 32'(val[10:0]); end
      REG_OMEGA_LIMIT:  begin cfg.omega_limit       = val[9:0];  want = 32'(val[9:0]);  end
      REG_FOLLOW_GAIN:  begin cfg.follow_gain       = val[5:0];  want = 32'(val[5:0]);  end
      default:          begin cfg.deadband_deg      = val[7:0];  want = 32'(val[7:0]);  end
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("register readback", want, got);
  endtask

  task automatic write_all(input cfg_t c);
    cfg_write_verify(REG_FORWARD_TIME, 32'(c.forward_time_ms));
    cfg_write_verify(REG_TURN_TIME,    32'(c.turn_time_ms));
    cfg_write_verify(REG_BACK_TIME,    32'(c.back_time_ms));
    cfg_write_verify(REG_WHEEL_RPM,    32'(c.routine_wheel_rpm));
    cfg_write_verify(REG_SPIN_CODE,    32'(c.spin_code));
    cfg_write_verify(REG_OMEGA_LIMIT,  32'(c.omega_limit));
    cfg_write_verify(REG_FOLLOW_GAIN,  32'(c.follow_gain));
    cfg_write_verify(REG_DEADBAND,     32'(c.deadband_deg));
  endtask

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.forward_time_ms   = RST_FORWARD_TIME;
    c.turn_time_ms      = RST_TURN_TIME;
    c.back_time_ms      = RST_BACK_TIME;
    c.routine_wheel_rpm = RST_WHEEL_RPM;
    c.spin_code         = RST_SPIN_CODE;
    c.omega_limit       = RST_OMEGA_LIMIT;
    c.follow_gain       = RST_FOLLOW_GAIN;
    c.deadband_deg      = RST_DEADBAND;
    return c;
  endfunction

  function automatic cfg_t extreme_cfg(input bit top);
    cfg_t c;
    c.forward_time_ms   = top ? 16'hFFFF : 16'd0;
    c.turn_time_ms      = top ? 16'hFFFF : 16'd0;
    c.back_time_ms      = top ? 16'hFFFF : 16'd0;
    c.routine_wheel_rpm = top ? 11'h7FF : 11'd0;
    c.spin_code         = top ? 11'h7FF : 11'd0;
    c.omega_limit       = top ? 10'h3FF : 10'd0;
    c.follow_gain       = top ? 6'h3F : 6'd0;
    c.deadband_deg      = top ? 8'd180 : 8'd0;
    return c;
  endfunction

  // mostly short phases so routines run to completion often
  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.forward_time_ms   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
    c.turn_time_ms      = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
    c.back_time_ms      = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
    c.routine_wheel_rpm = 11'($urandom);
    c.spin_code         = 11'($urandom);
    c.omega_limit       = 10'($urandom);
    c.follow_gain       = 6'($urandom);
    c.deadband_deg      = 8'($urandom_range(0, 180));
    return c;
  endfunction

  // ---------------------------------------------------------------- sender

  // offer one request and hold it until accepted
  task automatic send_item(input tick_req_t r, input int unsigned gap);
    in_valid_i       <= 1'b1;
    tick_ms_i        <= r.tick;
    switch_channel_i <= r.sw;
    gimbal_yaw_deg_i <= r.gimbal;
    body_yaw_i       <= r.body;
    follow_on_i      <= r.follow;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    chassis_cmd_q.push_back(next_chassis_cmd(r));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender pause: every pending result drained, then settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (chassis_cmd_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap(input bit gaps_on);
    int unsigned pick;
    if (!gaps_on) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tick_req_t mk_req(input logic [31:0] t, input logic [10:0] s,
                                       input int g, input int b, input bit f);
    tick_req_t r;
    r.tick   = t;
    r.sw     = s;
    r.gimbal = 16'(g);
    r.body   = 16'(b);
    r.follow = f;
    return r;
  endfunction

  // mostly trigger patterns and near-deadband yaw, the rest noise
  function automatic tick_req_t rand_tick_req();
    tick_req_t   r;
    int unsigned pick;
    int          deg;
    int          k;
    pick = $urandom_range(0, 99);
    if (pick < 60)      tick_clock += $urandom_range(0, 40);
    else if (pick < 85) tick_clock += $urandom_range(0, 70000);
    else if (pick < 95) tick_clock = $urandom;
    r.tick = tick_clock;
    pick = $urandom_range(0, 99);
    if (mode_auto || pick < 10) begin
      r.sw = 11'($urandom);
    end else if (pick < 55) begin
      r.sw = cfg.spin_code;
    end else begin
      r.sw = 11'($urandom);
      if (r.sw == cfg.spin_code) r.sw ^= 11'd1;
    end
    r.follow = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 9) < 4) begin
      r.gimbal = 16'($urandom);
      r.body   = 16'($urandom);
    end else begin
      r.body   = 16'(int'($urandom_range(0, 1200)) - 600);
      deg      = wrap_angle(yaw_to_deg(r.body));
      k        = int'(cfg.deadband_deg) + 3;
      r.gimbal = 16'(deg + YAW_OFFSET + int'($urandom_range(0, 2 * k)) - k);
    end
    return r;
  endfunction

  task automatic run_random_phase(input int n, input bit gaps_on);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_idle();
      send_item(rand_tick_req(), pick_gap(gaps_on));
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_register_access();
    write_all(extreme_cfg(1'b1));
    write_all(extreme_cfg(1'b0));
    write_all(default_cfg());
  endtask

  // spin without prior off, arming, firing, then all three phases across a tick wrap
  task automatic test_trigger_routine();
    logic [31:0] t0;
    t0 = 32'hFFFF_F000;
    send_item(mk_req(32'd100, 11'd770, 0, 0, 1'b1), 0);
    send_item(mk_req(32'd101, 11'd0, 0, 0, 1'b1), 1);
    send_item(mk_req(32'd102, 11'd770, 0, 0, 1'b1), 0);
    send_item(mk_req(32'd103, 11'd770, 0, 0, 1'b1), 0);
    send_item(mk_req(t0, 11'd2047, 0, 0, 1'b1), 2);
    send_item(mk_req(t0 + 32'd5999, 11'd770, 0, 0, 1'b1), 0);
    send_item(mk_req(t0 + 32'd6000, 11'd0, 0, 0, 1'b1), 0);
    send_item(mk_req(t0 + 32'd10999, 11'd0, 0, 0, 1'b1), 0);
    send_item(mk_req(t0 + 32'd11000, 11'd0, 0, 0, 1'b1), 0);
    send_item(mk_req(t0 + 32'd13999, 11'd0, 0, 0, 1'b1), 0);
    send_item(mk_req(t0 + 32'd14000, 11'd770, 0, 0, 1'b1), 0);
    send_item(mk_req(t0 + 32'd14001, 11'd5, 0, 0, 1'b1), 0);
    tick_clock = t0 + 32'd14001;
    wait_idle();
  endtask

  // deadband edges, wrap boundaries, field extremes, follow off, clamp
  task automatic test_yaw_follow_edges();
    send_item(mk_req(32'd0, 11'd0, 0, 0, 1'b1), 0);
    send_item(mk_req(32'd1, 11'd0, -4, 0, 1'b1), 0);
    send_item(mk_req(32'd2, 11'd0, -3, 0, 1'b1), 0);
    send_item(mk_req(32'd3, 11'd0, 12, 0, 1'b1), 0);
    send_item(mk_req(32'd4, 11'd0, 0, 32767, 1'b1), 0);
    send_item(mk_req(32'd5, 11'd0, 32767, -32768, 1'b1), 0);
    send_item(mk_req(32'd6, 11'd0, -32768, 0, 1'b1), 0);
    send_item(mk_req(32'd7, 11'd0, -32768, 32767, 1'b0), 0);
    send_item(mk_req(32'd8, 11'd0, -177, 0, 1'b1), 0);
    send_item(mk_req(32'd9, 11'd0, -176, 0, 1'b1), 0);
    send_item(mk_req(32'd10, 11'd0, 184, 0, 1'b1), 0);
    send_item(mk_req(32'd11, 11'd0, 185, 0, 1'b1), 0);
    wait_idle();
    cfg_write_verify(REG_FOLLOW_GAIN, 32'd63);
    cfg_write_verify(REG_OMEGA_LIMIT, 32'd1023);
    send_item(mk_req(32'd12, 11'd0, -176, 0, 1'b1), 0);
    send_item(mk_req(32'd13, 11'd0, 184, 0, 1'b1), 0);
    wait_idle();
    write_all(default_cfg());
  endtask

  task automatic test_random_settings();
    run_random_phase(200, 1'b1);
    write_all(extreme_cfg(1'b0));
    run_random_phase(150, 1'b0);
    write_all(extreme_cfg(1'b1));
    run_random_phase(250, 1'b1);
    for (int j = 0; j < 6; j++) begin
      write_all(rand_cfg());
      run_random_phase(230, j[0]);
    end
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_item(rand_tick_req(), 0);
    wait_idle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    cfg = default_cfg();
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid_i       <= 1'b0;
    tick_ms_i        <= '0;
    switch_channel_i <= '0;
    gimbal_yaw_deg_i <= '0;
    body_yaw_i       <= '0;
    follow_on_i      <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_trigger_routine();
    test_yaw_follow_edges();
    test_random_settings();
    test_backpressure();

    repeat (20) @(posedge clk_i);
    if (err_count == 0 && chassis_cmd_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cmsy_pkg.sv
rtl/core/cmsy_ctrl.sv
rtl/core/cmsy_dp.sv
rtl/core/chassis_mode_sequencer_yaw_follow_unit.sv
bench/tb_chassis_mode_sequencer_yaw_follow_unit.sv
